### rtl/ed2k_pkg.sv
`default_nettype none
package ed2k_pkg;

  localparam logic [23:0] ChunkBytes = 24'd9728000;

  typedef logic [3:0][31:0] chain_t;

  localparam chain_t Md4Iv = {32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301};

  localparam logic SelInner = 1'b0;
  localparam logic SelOuter = 1'b1;

  // padding control for one compression: bytes below lim come from memory,
  // byte lim is 0x80 when mark is set, the rest are zero; len_en puts the
  // bit length into words 14 and 15
  typedef struct packed {
    logic [6:0]  lim;
    logic        mark;
    logic        len_en;
    logic [63:0] len;
  } pad_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_RUN,
    ENG_ADD
  } eng_state_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_ABSORB,
    S_NWAIT,
    S_POST,
    S_FINCHK,
    S_PAD1,
    S_P1W,
    S_PAD2,
    S_P2W,
    S_DIGWR,
    S_OWAIT,
    S_CEND,
    S_FINAL,
    S_RESULT
  } seq_state_e;

  typedef enum logic [1:0] {
    RET_ABSORB,
    RET_FINCHK,
    RET_FINAL
  } ret_e;

  // message word used by MD4 step i
  function automatic logic [3:0] md4_word(input logic [5:0] i);
    logic [3:0] j;
    logic [3:0] w;
    j = i[3:0];
    case (i[5:4])
      2'd0:    w = j;
      2'd1:    w = {j[1:0], j[3:2]};
      2'd2:    w = {j[0], j[1], j[2], j[3]};
      default: w = 4'd0;
    endcase
    return w;
  endfunction

  function automatic logic [4:0] md4_shift(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'b0000: s = 5'd3;
      4'b0001: s = 5'd7;
      4'b0010: s = 5'd11;
      4'b0011: s = 5'd19;
      4'b0100: s = 5'd3;
      4'b0101: s = 5'd5;
      4'b0110: s = 5'd9;
      4'b0111: s = 5'd13;
      4'b1000: s = 5'd3;
      4'b1001: s = 5'd9;
      4'b1010: s = 5'd11;
      4'b1011: s = 5'd15;
      default: s = 5'd3;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

### rtl/ed2k_blk_ram.sv
`default_nettype none
module ed2k_blk_ram (
  input  wire logic        clk_i,
  input  wire logic        we_i,
  input  wire logic [4:0]  waddr_i,
  input  wire logic [3:0]  be_i,
  input  wire logic [31:0] wdata_i,
  input  wire logic [4:0]  raddr_i,
  output logic      [31:0] rdata_o
);

  logic [31:0] mem_q [32];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 4; j++) begin
      if (we_i && be_i[j]) begin
        mem_q[waddr_i][8*j +: 8] <= wdata_i[8*j +: 8];
      end
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### rtl/ed2k_md4_core.sv
`default_nettype none
module ed2k_md4_core (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire ed2k_pkg::chain_t     chain_i,
  input  wire ed2k_pkg::pad_t       pad_i,
  output logic      [3:0]           rd_addr_o,
  input  wire logic [31:0]          rd_data_i,
  output logic                      done_o,
  output ed2k_pkg::chain_t          chain_o
);

  ed2k_pkg::eng_state_e state_q, state_d;
  logic [5:0]       cnt_q, cnt_d;
  logic [31:0]      a_q, b_q, c_q, d_q, a_d, b_d, c_d, d_d;
  ed2k_pkg::chain_t save_q, save_d;
  ed2k_pkg::pad_t   pad_q, pad_d;

  logic [5:0]  rd_idx;
  logic [3:0]  xw;
  logic [31:0] x;
  logic [31:0] f;
  logic [31:0] sum;
  logic [4:0]  sh;
  logic [31:0] t;

  always_comb begin
    if (state_q != ed2k_pkg::ENG_RUN || cnt_q == 6'd47) begin
      rd_idx = 6'd0;
    end else begin
      rd_idx = cnt_q + 6'd1;
    end
  end
  assign rd_addr_o = ed2k_pkg::md4_word(rd_idx);

  // apply padding and length to the word read from memory
  always_comb begin
    logic [6:0] b;
    xw = ed2k_pkg::md4_word(cnt_q);
    for (int j = 0; j < 4; j++) begin
      b = {1'b0, xw, 2'(j)};
      if (b < pad_q.lim) begin
        x[8*j +: 8] = rd_data_i[8*j +: 8];
      end else if (b == pad_q.lim && pad_q.mark) begin
        x[8*j +: 8] = 8'h80;
      end else begin
        x[8*j +: 8] = 8'h00;
      end
    end
    if (pad_q.len_en && xw == 4'd14) begin
      x = pad_q.len[31:0];
    end else if (pad_q.len_en && xw == 4'd15) begin
      x = pad_q.len[63:32];
    end
  end

  always_comb begin
    case (cnt_q[5:4])
      2'd0:    f = (b_q & c_q) | (~b_q & d_q);
      2'd1:    f = ((b_q & c_q) | (b_q & d_q) | (c_q & d_q)) + 32'h5A827999;
      default: f = (b_q ^ c_q ^ d_q) + 32'h6ED9EBA1;
    endcase
    sum = a_q + f + x;
    sh  = ed2k_pkg::md4_shift(cnt_q);
    t   = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    a_d     = a_q;
    b_d     = b_q;
    c_d     = c_q;
    d_d     = d_q;
    save_d  = save_q;
    pad_d   = pad_q;
    case (state_q)
      ed2k_pkg::ENG_IDLE: begin
        if (start_i) begin
          a_d     = chain_i[0];
          b_d     = chain_i[1];
          c_d     = chain_i[2];
          d_d     = chain_i[3];
          save_d  = chain_i;
          pad_d   = pad_i;
          cnt_d   = 6'd0;
          state_d = ed2k_pkg::ENG_RUN;
        end
      end
      ed2k_pkg::ENG_RUN: begin
        a_d   = d_q;
        d_d   = c_q;
        c_d   = b_q;
        b_d   = t;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd47) begin
          state_d = ed2k_pkg::ENG_ADD;
        end
      end
      ed2k_pkg::ENG_ADD: begin
        state_d = ed2k_pkg::ENG_IDLE;
      end
      default: state_d = ed2k_pkg::ENG_IDLE;
    endcase
  end

  always_comb begin
    done_o     = (state_q == ed2k_pkg::ENG_ADD);
    chain_o[0] = save_q[0] + a_q;
    chain_o[1] = save_q[1] + b_q;
    chain_o[2] = save_q[2] + c_q;
    chain_o[3] = save_q[3] + d_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ed2k_pkg::ENG_IDLE;
      cnt_q   <= 6'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    c_q    <= c_d;
    d_q    <= d_d;
    save_q <= save_d;
    pad_q  <= pad_d;
  end

endmodule
`default_nettype wire

### rtl/ed2k_chunked_md4_hash.sv
`default_nettype none
// Channel    Dir  Payload
// s_axis     in   tdata: data_byte; tuser: byte_valid; tlast: finish
// m_axis     out  tdata: digest_low, digest_high
// cfg        in   cfg_wdata_i: legacy_mode, written when cfg_we_i is high
//
// After acceptance a byte request passes DECIDE, ABSORB, POST and FINCHK before
// ready returns in IDLE, a request without a byte DECIDE and FINCHK; each MD4
// compression it triggers adds a start, 48 steps of the single round unit with
// one word read per step, and an add. A chunk close adds one or two padded
// compressions, four digest writes and possibly an outer compression. Reset
// restores the initial chains at once; no clearing pass. A result waiting on
// m_axis stalls the block only when the next one is done.
module ed2k_chunked_md4_hash (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  wire logic         s_axis_tuser,   // [0] byte_valid
  input  wire logic         s_axis_tlast,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic      [127:0] m_axis_tdata,   // [63:0] digest_low, [127:64] digest_high
  input  wire logic         cfg_we_i,
  input  wire logic         cfg_wdata_i
);

  ed2k_pkg::seq_state_e state_q, state_d;
  ed2k_pkg::ret_e       ret_q, ret_d;
  logic             fsel_q, fsel_d;
  logic             fin_ctx_q, fin_ctx_d;
  logic             esel_q, esel_d;
  ed2k_pkg::chain_t ich_q, ich_d, och_q, och_d;
  logic [23:0]      fill_q, fill_d;
  logic [31:0]      closed_q, closed_d;
  logic [7:0]       byte_q, byte_d;
  logic             bv_q, bv_d;
  logic             fin_q, fin_d;
  logic [1:0]       k_q, k_d;
  logic             legacy_q, legacy_d;
  logic             out_valid_q, out_valid_d;
  logic [127:0]     out_data_q, out_data_d;

  logic             eng_start;
  logic             st_sel;
  ed2k_pkg::pad_t   eng_pad;
  ed2k_pkg::chain_t eng_chain_in;
  ed2k_pkg::chain_t eng_chain_out;
  logic             eng_done;
  logic [3:0]       eng_rd_addr;
  logic [31:0]      ram_rdata;
  logic             ram_we;
  logic [4:0]       ram_waddr;
  logic [3:0]       ram_be;
  logic [31:0]      ram_wdata;

  logic [5:0]       pad_pos;
  logic [63:0]      pad_len;
  logic             pad_two;
  ed2k_pkg::chain_t fchain;

  assign pad_pos = fsel_q ? {closed_q[1:0], 4'd0} : fill_q[5:0];
  assign pad_len = fsel_q ? {25'd0, closed_q, 7'd0} : {37'd0, fill_q, 3'd0};
  assign pad_two = (pad_pos >= 6'd56);
  assign fchain  = fsel_q ? och_q : ich_q;

  // datapath controls
  always_comb begin
    eng_start   = 1'b0;
    st_sel      = ed2k_pkg::SelInner;
    eng_pad.lim    = 7'd64;
    eng_pad.mark   = 1'b0;
    eng_pad.len_en = 1'b0;
    eng_pad.len    = pad_len;
    ram_we      = 1'b0;
    ram_waddr   = {ed2k_pkg::SelInner, fill_q[5:2]};
    ram_be      = 4'd0;
    ram_wdata   = {4{byte_q}};
    case (state_q)
      ed2k_pkg::S_ABSORB: begin
        ram_we = 1'b1;
        ram_be = 4'd1 << fill_q[1:0];
        if (fill_q[5:0] == 6'd63) begin
          eng_start = 1'b1;
        end
      end
      ed2k_pkg::S_PAD1: begin
        eng_start      = 1'b1;
        st_sel         = fsel_q;
        eng_pad.lim    = {1'b0, pad_pos};
        eng_pad.mark   = 1'b1;
        eng_pad.len_en = !pad_two;
      end
      ed2k_pkg::S_PAD2: begin
        eng_start      = 1'b1;
        st_sel         = fsel_q;
        eng_pad.lim    = 7'd0;
        eng_pad.len_en = 1'b1;
      end
      ed2k_pkg::S_DIGWR: begin
        ram_we    = 1'b1;
        ram_waddr = {ed2k_pkg::SelOuter, closed_q[1:0], k_q};
        ram_be    = 4'hF;
        ram_wdata = ich_q[k_q];
        if (k_q == 2'd3 && closed_q[1:0] == 2'd3) begin
          eng_start = 1'b1;
          st_sel    = ed2k_pkg::SelOuter;
        end
      end
      default: ;
    endcase
    eng_chain_in = st_sel ? och_q : ich_q;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    fsel_d      = fsel_q;
    fin_ctx_d   = fin_ctx_q;
    esel_d      = eng_start ? st_sel : esel_q;
    ich_d       = ich_q;
    och_d       = och_q;
    fill_d      = fill_q;
    closed_d    = closed_q;
    byte_d      = byte_q;
    bv_d        = bv_q;
    fin_d       = fin_q;
    k_d         = k_q;
    legacy_d    = cfg_we_i ? cfg_wdata_i : legacy_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;

    if (eng_done) begin
      if (esel_q) begin
        och_d = eng_chain_out;
      end else begin
        ich_d = eng_chain_out;
      end
    end

    case (state_q)
      ed2k_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          byte_d  = s_axis_tdata;
          bv_d    = s_axis_tuser;
          fin_d   = s_axis_tlast;
          state_d = ed2k_pkg::S_DECIDE;
        end
      end
      ed2k_pkg::S_DECIDE: begin
        if (!bv_q) begin
          state_d = ed2k_pkg::S_FINCHK;
        end else if (fill_q >= ed2k_pkg::ChunkBytes) begin
          // close the pending full chunk before taking the byte
          ret_d     = ed2k_pkg::RET_ABSORB;
          fsel_d    = ed2k_pkg::SelInner;
          fin_ctx_d = 1'b0;
          state_d   = ed2k_pkg::S_PAD1;
        end else begin
          state_d = ed2k_pkg::S_ABSORB;
        end
      end
      ed2k_pkg::S_ABSORB: begin
        fill_d  = fill_q + 24'd1;
        state_d = (fill_q[5:0] == 6'd63) ? ed2k_pkg::S_NWAIT : ed2k_pkg::S_POST;
      end
      ed2k_pkg::S_NWAIT: begin
        if (eng_done) begin
          state_d = ed2k_pkg::S_POST;
        end
      end
      ed2k_pkg::S_POST: begin
        if (fill_q >= ed2k_pkg::ChunkBytes && !legacy_q) begin
          ret_d     = ed2k_pkg::RET_FINCHK;
          fsel_d    = ed2k_pkg::SelInner;
          fin_ctx_d = 1'b0;
          state_d   = ed2k_pkg::S_PAD1;
        end else begin
          state_d = ed2k_pkg::S_FINCHK;
        end
      end
      ed2k_pkg::S_FINCHK: begin
        if (!fin_q) begin
          state_d = ed2k_pkg::S_IDLE;
        end else if (closed_q != 32'd0) begin
          if (fill_q != 24'd0 || !legacy_q) begin
            ret_d     = ed2k_pkg::RET_FINAL;
            fsel_d    = ed2k_pkg::SelInner;
            fin_ctx_d = 1'b0;
            state_d   = ed2k_pkg::S_PAD1;
          end else begin
            state_d = ed2k_pkg::S_FINAL;
          end
        end else begin
          fsel_d    = ed2k_pkg::SelInner;
          fin_ctx_d = 1'b1;
          state_d   = ed2k_pkg::S_PAD1;
        end
      end
      ed2k_pkg::S_PAD1: state_d = ed2k_pkg::S_P1W;
      ed2k_pkg::S_P1W: begin
        if (eng_done) begin
          if (pad_two) begin
            state_d = ed2k_pkg::S_PAD2;
          end else if (fin_ctx_q) begin
            state_d = ed2k_pkg::S_RESULT;
          end else begin
            k_d     = 2'd0;
            state_d = ed2k_pkg::S_DIGWR;
          end
        end
      end
      ed2k_pkg::S_PAD2: state_d = ed2k_pkg::S_P2W;
      ed2k_pkg::S_P2W: begin
        if (eng_done) begin
          if (fin_ctx_q) begin
            state_d = ed2k_pkg::S_RESULT;
          end else begin
            k_d     = 2'd0;
            state_d = ed2k_pkg::S_DIGWR;
          end
        end
      end
      ed2k_pkg::S_DIGWR: begin
        k_d = k_q + 2'd1;
        if (k_q == 2'd3) begin
          ich_d   = ed2k_pkg::Md4Iv;
          fill_d  = 24'd0;
          state_d = (closed_q[1:0] == 2'd3) ? ed2k_pkg::S_OWAIT : ed2k_pkg::S_CEND;
        end
      end
      ed2k_pkg::S_OWAIT: begin
        if (eng_done) begin
          state_d = ed2k_pkg::S_CEND;
        end
      end
      ed2k_pkg::S_CEND: begin
        closed_d = closed_q + 32'd1;
        case (ret_q)
          ed2k_pkg::RET_ABSORB: state_d = ed2k_pkg::S_ABSORB;
          ed2k_pkg::RET_FINCHK: state_d = ed2k_pkg::S_FINCHK;
          default:              state_d = ed2k_pkg::S_FINAL;
        endcase
      end
      ed2k_pkg::S_FINAL: begin
        fsel_d    = ed2k_pkg::SelOuter;
        fin_ctx_d = 1'b1;
        state_d   = ed2k_pkg::S_PAD1;
      end
      ed2k_pkg::S_RESULT: begin
        // hold until the output register is free
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = fchain;
          ich_d       = ed2k_pkg::Md4Iv;
          och_d       = ed2k_pkg::Md4Iv;
          fill_d      = 24'd0;
          closed_d    = 32'd0;
          state_d     = ed2k_pkg::S_IDLE;
        end
      end
      default: state_d = ed2k_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ed2k_pkg::S_IDLE;
      ret_q       <= ed2k_pkg::RET_ABSORB;
      fsel_q      <= ed2k_pkg::SelInner;
      fin_ctx_q   <= 1'b0;
      esel_q      <= ed2k_pkg::SelInner;
      ich_q       <= ed2k_pkg::Md4Iv;
      och_q       <= ed2k_pkg::Md4Iv;
      fill_q      <= 24'd0;
      closed_q    <= 32'd0;
      k_q         <= 2'd0;
      legacy_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      fsel_q      <= fsel_d;
      fin_ctx_q   <= fin_ctx_d;
      esel_q      <= esel_d;
      ich_q       <= ich_d;
      och_q       <= och_d;
      fill_q      <= fill_d;
      closed_q    <= closed_d;
      k_q         <= k_d;
      legacy_q    <= legacy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    bv_q       <= bv_d;
    fin_q      <= fin_d;
    out_data_q <= out_data_d;
  end

  ed2k_blk_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .be_i    (ram_be),
    .wdata_i (ram_wdata),
    .raddr_i ({esel_d, eng_rd_addr}),
    .rdata_o (ram_rdata)
  );

  ed2k_md4_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (eng_start),
    .chain_i   (eng_chain_in),
    .pad_i     (eng_pad),
    .rd_addr_o (eng_rd_addr),
    .rd_data_i (ram_rdata),
    .done_o    (eng_done),
    .chain_o   (eng_chain_out)
  );

  assign s_axis_tready = (state_q == ed2k_pkg::S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= ed2k_pkg::ChunkBytes)
    else $error("chunk fill beyond chunk size");

  a_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_done |-> (state_q == ed2k_pkg::S_NWAIT || state_q == ed2k_pkg::S_P1W ||
                  state_q == ed2k_pkg::S_P2W || state_q == ed2k_pkg::S_OWAIT))
    else $error("compression finished outside a wait state");

  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ed2k_pkg::S_DIGWR && k_q == 2'd3) |=> fill_q == 24'd0)
    else $error("chunk close left fill count");
`endif

endmodule
`default_nettype wire

### bench/ed2k_chunked_md4_hash_test.sv
module ed2k_chunked_md4_hash_test;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned DrainCycles = 400;

  typedef logic [63:0][7:0] block_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       finish;
  } byte_req_t;

  localparam int RoundShift [12] = '{3, 7, 11, 19, 3, 5, 9, 13, 3, 9, 11, 15};

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;
  logic         s_axis_tuser;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;
  logic         cfg_we_i;
  logic         cfg_wdata_i;

  ed2k_chunked_md4_hash DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  byte_req_t    byte_q[$];
  logic [127:0] digest_q[$];

  // shadow hash state
  ed2k_pkg::chain_t inner_h, outer_h;
  block_t       inner_buf, outer_buf;
  int unsigned  chunk_len;
  int unsigned  chunk_count;
  logic         legacy;

  int unsigned  cycles = 0;
  int unsigned  errors = 0;
  int unsigned  digests_seen = 0;
  int unsigned  msgs_sent = 0;
  int unsigned  bytes_sent = 0;
  int unsigned  idle_send = 0;
  int unsigned  idle_recv = 0;
  int unsigned  n_presented = 0;
  int unsigned  n_accepted = 0;

  function automatic logic [31:0] rotl(logic [31:0] v, int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic ed2k_pkg::chain_t md4_block(ed2k_pkg::chain_t h, block_t b);
    logic [31:0] a, bb, c, d, f, t;
    logic [31:0] x [16];
    int          r, j, w;
    a = h[0]; bb = h[1]; c = h[2]; d = h[3];
    for (int i = 0; i < 16; i++) x[i] = b[4*i +: 4];
    for (int i = 0; i < 48; i++) begin
      r = i / 16;
      j = i % 16;
      if (r == 0) begin
        f = (bb & c) | (~bb & d);
        w = j;
      end else if (r == 1) begin
        f = ((bb & c) | (bb & d) | (c & d)) + 32'h5A827999;
        w = (j % 4) * 4 + j / 4;
      end else begin
        f = (bb ^ c ^ d) + 32'h6ED9EBA1;
        w = {j[0], j[1], j[2], j[3]};
      end
      t = rotl(a + f + x[w], RoundShift[r*4 + (i % 4)]);
      a = d; d = c; c = bb; bb = t;
    end
    h[0] += a; h[1] += bb; h[2] += c; h[3] += d;
    return h;
  endfunction

  // pad and finish; the chain words are the digest bytes in order
  function automatic ed2k_pkg::chain_t md4_pad(ed2k_pkg::chain_t h, block_t b,
                                               logic [63:0] len);
    int          pos;
    logic [63:0] bits;
    pos = len[5:0];
    bits = len << 3;
    b[pos] = 8'h80;
    pos++;
    if (pos > 56) begin
      for (int i = pos; i < 64; i++) b[i] = 8'h00;
      h = md4_block(h, b);
      pos = 0;
    end
    for (int i = pos; i < 56; i++) b[i] = 8'h00;
    for (int i = 0; i < 8; i++) b[56+i] = bits[8*i +: 8];
    return md4_block(h, b);
  endfunction

  function automatic void close_chunk();
    ed2k_pkg::chain_t dig;
    logic [63:0]      base;
    dig = md4_pad(inner_h, inner_buf, 64'(chunk_len));
    inner_h = ed2k_pkg::Md4Iv;
    chunk_len = 0;
    base = 64'(chunk_count) * 16;
    for (int i = 0; i < 16; i++) begin
      outer_buf[(base + i) % 64] = dig[i/4][8*(i%4) +: 8];
      if ((base + i) % 64 == 63) outer_h = md4_block(outer_h, outer_buf);
    end
    chunk_count++;
  endfunction

  function automatic void clear_hash();
    inner_h = ed2k_pkg::Md4Iv;
    outer_h = ed2k_pkg::Md4Iv;
    inner_buf = '0;
    outer_buf = '0;
    chunk_len = 0;
    chunk_count = 0;
  endfunction

  function automatic void hash_byte(byte_req_t q);
    ed2k_pkg::chain_t dig;
    if (q.byte_valid) begin
      if (chunk_len >= ed2k_pkg::ChunkBytes) close_chunk();
      inner_buf[chunk_len % 64] = q.data_byte;
      if (chunk_len % 64 == 63) inner_h = md4_block(inner_h, inner_buf);
      chunk_len++;
      if (chunk_len >= ed2k_pkg::ChunkBytes && !legacy) close_chunk();
    end
    if (q.finish) begin
      if (chunk_count != 0) begin
        if (chunk_len != 0 || !legacy) close_chunk();
        dig = md4_pad(outer_h, outer_buf, 64'(chunk_count) * 16);
      end else begin
        dig = md4_pad(inner_h, inner_buf, 64'(chunk_len));
      end
      digest_q.push_back(dig);
      clear_hash();
    end
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d digests pending", cycles, digest_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // sample both handshakes and predict on each accepted request
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      hash_byte(byte_q.pop_front());
      n_accepted++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      digests_seen++;
      if (digest_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected digest %h", m_axis_tdata);
      end else begin
        logic [127:0] want;
        want = digest_q.pop_front();
        if (m_axis_tdata[63:0] !== want[63:0] || m_axis_tdata[127:64] !== want[127:64]) begin
          errors++;
          if (errors <= 10)
            $display("digest mismatch: low exp %h got %h, high exp %h got %h",
                     want[63:0], m_axis_tdata[63:0], want[127:64], m_axis_tdata[127:64]);
        end
      end
    end
  end

  // drive requests from the queue; hold data while valid is up
  always @(negedge clk_i) begin
    logic nv;
    nv = s_axis_tvalid && (n_accepted != n_presented);
    if (!nv && byte_q.size() > 0 && $urandom_range(99) >= idle_send) begin
      nv = 1'b1;
      n_presented++;
      s_axis_tdata <= byte_q[0].data_byte;
      s_axis_tuser <= byte_q[0].byte_valid;
      s_axis_tlast <= byte_q[0].finish;
    end
    s_axis_tvalid <= nv;
    m_axis_tready <= ($urandom_range(99) >= idle_recv);
  end

  task automatic push_msg(int unsigned len);
    byte_req_t q;
    logic      sep;
    sep = (len == 0) || ($urandom_range(3) == 0);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(15) == 0) begin
        q.data_byte = 8'($urandom);
        q.byte_valid = 1'b0;
        q.finish = 1'b0;
        byte_q.push_back(q);
      end
      q.data_byte = 8'($urandom);
      q.byte_valid = 1'b1;
      q.finish = !sep && (i == len - 1);
      byte_q.push_back(q);
    end
    if (sep) begin
      q.data_byte = 8'($urandom);
      q.byte_valid = 1'b0;
      q.finish = 1'b1;
      byte_q.push_back(q);
    end
    msgs_sent++;
    bytes_sent += len;
  endtask

  task automatic wait_idle();
    while (byte_q.size() > 0 || digest_q.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_mode(logic v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    legacy = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    static int unsigned lens [8] = '{55, 56, 57, 63, 64, 65, 119, 120};
    byte_req_t q;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 1'b0;
    legacy = 1'b0;
    clear_hash();
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_mode(1'b1);
    // directed: empty message, byte extremes, finish alone and with a byte, noise
    push_msg(0);
    q = '{data_byte: 8'hFF, byte_valid: 1'b1, finish: 1'b1};
    byte_q.push_back(q);
    q = '{data_byte: 8'h00, byte_valid: 1'b1, finish: 1'b0};
    byte_q.push_back(q);
    q = '{data_byte: 8'hFF, byte_valid: 1'b0, finish: 1'b0};
    byte_q.push_back(q);
    q = '{data_byte: 8'h00, byte_valid: 1'b0, finish: 1'b1};
    byte_q.push_back(q);
    push_msg(3);
    push_msg(0);
    msgs_sent += 2;
    bytes_sent += 2;
    wait_idle();
    write_mode(1'b0);

    for (int ph = 0; ph < 3; ph++) begin
      idle_send = (ph == 0) ? 17 : (ph == 1) ? 45 : 0;
      idle_recv = (ph == 0) ? 45 : (ph == 1) ? 17 : 0;
      for (int unsigned n = 0; n < 250; ) begin
        int unsigned len;
        len = ($urandom_range(7) == 0) ? lens[$urandom_range(7)] : $urandom_range(20);
        push_msg(len);
        n += len + 1;
      end
      // let every digest drain before changing the mode
      wait_idle();
      write_mode(ph[0] ? 1'b0 : 1'b1);
    end

    wait_idle();
    $display("%0d messages, %0d message bytes, %0d digests checked, both modes",
             msgs_sent, bytes_sent, digests_seen);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
